/* design/adte_pkg.sv */
// ----------------------------------------------------------------------------
// adte_pkg: shared types and constants of the dialogue text extractor
// Holds the payload structs, the command word passed from the front part to
// the back part, the register indexes and the character codes.
// ----------------------------------------------------------------------------
package adte_pkg;

  // Width of the count/address field of a command; covers digit stores of up
  // to 63 entries together with a full count.
  localparam int unsigned CMD_CNT_W = 6;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_FIELDS_BEFORE_TEXT = 1'b0;
  localparam logic CFG_LEGACY_NUMBER_SKIP = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPERN = 8'h4E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LOWERH = 8'h68;
  localparam logic [7:0] CH_LOWERN = 8'h6E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Reset values of the configuration registers.
  localparam logic [3:0] FIELDS_RESET = 4'd9;
  localparam logic       LEGACY_RESET = 1'b1;

  // One input item.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_end;
  } res_item_t;

  // Configuration as seen by the front part.
  typedef struct packed {
    logic [3:0] fields_before_text;
    logic       legacy_number_skip;
  } cfg_t;

  // Operations carried out by the back part.
  typedef enum logic [1:0] {
    CMD_EMIT  = 2'd0,
    CMD_STORE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_END   = 2'd3
  } cmd_op_e;

  // Command word: data is the byte to emit or store, cnt is the store
  // address or the number of digits to flush.
  typedef struct packed {
    cmd_op_e              op;
    logic [7:0]           data;
    logic [CMD_CNT_W-1:0] cnt;
  } cmd_t;

endpackage

/* design/adte_front.sv */
// ----------------------------------------------------------------------------
// adte_front: input classifier
// Runs the line parser on each accepted byte and turns it into up to three
// commands, pushed into the command queue one per cycle while it has room.
// ----------------------------------------------------------------------------
module adte_front #(
  parameter int unsigned DIGIT_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  adte_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  adte_pkg::in_item_t in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output adte_pkg::cmd_t    cmd_o
);
  import adte_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIGIT_DEPTH + 1);

  // Parser phases.
  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_TEXT   = 3'd2;
  localparam logic [2:0] PH_BRACE  = 3'd3;
  localparam logic [2:0] PH_BSL    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       comma_q, comma_d;
  logic [CNT_W-1:0] dcnt_q, dcnt_d;
  logic [1:0]       step_q, step_d;

  cmd_t       cmds [3];
  logic [1:0] ncmd;
  logic       go;
  logic [7:0] b;
  logic       is_digit;
  logic       last_step;
  logic       accept;

  assign b        = in_i.in_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // Parse one byte: the phase may fall through several handlers in a row.
  always_comb begin
    phase_d = phase_q;
    comma_d = comma_q;
    dcnt_d  = dcnt_q;
    go      = 1'b1;
    ncmd    = 2'd0;
    for (int k = 0; k < 3; k++) begin
      cmds[k] = '{op: CMD_EMIT, data: 8'h00, cnt: '0};
    end

    // Skipping the leading fields.
    if (phase_d == PH_SKIP) begin
      if (comma_q >= cfg_i.fields_before_text) begin
        phase_d = cfg_i.legacy_number_skip ? PH_DIGITS : PH_TEXT;
        dcnt_d  = '0;
      end else begin
        go = 1'b0;
        if (b == CH_NUL) begin
          phase_d = PH_DONE;
        end else if (b == CH_COMMA) begin
          comma_d = comma_q + 4'd1;
        end
      end
    end

    // Buffering a possible number field.
    if (go && phase_d == PH_DIGITS) begin
      if (is_digit && dcnt_d < CNT_W'(DIGIT_DEPTH)) begin
        cmds[ncmd] = '{op: CMD_STORE, data: b, cnt: CMD_CNT_W'(dcnt_d)};
        ncmd       = ncmd + 2'd1;
        dcnt_d     = dcnt_d + CNT_W'(1);
        go         = 1'b0;
      end else if (!is_digit && b == CH_COMMA && dcnt_d != '0) begin
        dcnt_d  = '0;
        phase_d = PH_TEXT;
        go      = 1'b0;
      end else begin
        if (dcnt_d != '0) begin
          cmds[ncmd] = '{op: CMD_FLUSH, data: 8'h00, cnt: CMD_CNT_W'(dcnt_d)};
          ncmd       = ncmd + 2'd1;
        end
        dcnt_d  = '0;
        phase_d = PH_TEXT;
      end
    end

    // Byte after a backslash.
    if (go && phase_d == PH_BSL) begin
      if (b == CH_UPPERN || b == CH_LOWERN) begin
        cmds[ncmd] = '{op: CMD_EMIT, data: CH_LF, cnt: '0};
        ncmd       = ncmd + 2'd1;
        phase_d    = PH_TEXT;
        go         = 1'b0;
      end else if (b == CH_LOWERH) begin
        cmds[ncmd] = '{op: CMD_EMIT, data: CH_SPACE, cnt: '0};
        ncmd       = ncmd + 2'd1;
        phase_d    = PH_TEXT;
        go         = 1'b0;
      end else begin
        cmds[ncmd] = '{op: CMD_EMIT, data: CH_BSL, cnt: '0};
        ncmd       = ncmd + 2'd1;
        phase_d    = PH_TEXT;
      end
    end

    // Plain text.
    if (go && phase_d == PH_TEXT) begin
      go = 1'b0;
      if (b == CH_NUL || b == CH_LF || b == CH_CR) begin
        phase_d = PH_DONE;
      end else if (b == CH_LBRACE) begin
        phase_d = PH_BRACE;
      end else if (b == CH_BSL) begin
        phase_d = PH_BSL;
      end else begin
        cmds[ncmd] = '{op: CMD_EMIT, data: b, cnt: '0};
        ncmd       = ncmd + 2'd1;
      end
    end

    // Inside an override block.
    if (go && phase_d == PH_BRACE) begin
      go = 1'b0;
      if (b == CH_NUL) begin
        phase_d = PH_DONE;
      end else if (b == CH_RBRACE) begin
        phase_d = PH_TEXT;
      end
    end

    // Terminated line or an unknown phase code: ignore the byte.
    if (go) begin
      phase_d = PH_DONE;
    end

    // End of the line: drain pending state and close with the end marker.
    if (in_i.in_last) begin
      if (phase_d == PH_DIGITS && dcnt_d != '0) begin
        cmds[ncmd] = '{op: CMD_FLUSH, data: 8'h00, cnt: CMD_CNT_W'(dcnt_d)};
        ncmd       = ncmd + 2'd1;
      end else if (phase_d == PH_BSL) begin
        cmds[ncmd] = '{op: CMD_EMIT, data: CH_BSL, cnt: '0};
        ncmd       = ncmd + 2'd1;
      end
      cmds[ncmd] = '{op: CMD_END, data: 8'h00, cnt: '0};
      ncmd       = ncmd + 2'd1;
      phase_d    = PH_SKIP;
      comma_d    = 4'd0;
      dcnt_d     = '0;
    end
  end

  // Commands go out one per queue-ready cycle; the byte is taken with its last.
  assign last_step   = (step_q == ncmd - 2'd1);
  assign cmd_valid_o = in_valid_i && (ncmd != 2'd0);
  assign cmd_o       = cmds[step_q];
  assign in_ready_o  = (ncmd == 2'd0) || (cmd_ready_i && last_step);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    step_d = step_q;
    if (accept) begin
      step_d = 2'd0;
    end else if (cmd_valid_o && cmd_ready_i) begin
      step_d = step_q + 2'd1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      comma_q <= 4'd0;
      dcnt_q  <= '0;
      step_q  <= 2'd0;
    end else begin
      step_q <= step_d;
      if (accept) begin
        phase_q <= phase_d;
        comma_q <= comma_d;
        dcnt_q  <= dcnt_d;
      end
    end
  end

endmodule

/* design/adte_queue.sv */
// ----------------------------------------------------------------------------
// adte_queue: command queue
// A short first-in first-out buffer that decouples the front part from the
// back part.
// ----------------------------------------------------------------------------
module adte_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  adte_pkg::cmd_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output adte_pkg::cmd_t pop_o
);
  import adte_pkg::*;

  cmd_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = store_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill level update.
  always_comb begin
    wptr_d = push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wptr_q] <= push_i;
    end
  end

endmodule

/* design/adte_back.sv */
// ----------------------------------------------------------------------------
// adte_back: command executor
// Holds the digit store, carries out the queued commands and drives the
// result register.
// ----------------------------------------------------------------------------
module adte_back #(
  parameter int unsigned DIGIT_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  adte_pkg::cmd_t      cmd_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output adte_pkg::res_item_t res_o
);
  import adte_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned ADDR_W = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;

  localparam logic BK_IDLE  = 1'b0;
  localparam logic BK_FLUSH = 1'b1;

  logic [7:0]       digits [DIGIT_DEPTH];
  logic             st_q, st_d;
  logic [CNT_W-1:0] fidx_q, fidx_d;
  logic [CNT_W-1:0] fcnt_q, fcnt_d;
  logic             rvld_q, rvld_d;
  logic [7:0]       rdata_q;
  res_item_t        res_q, res_d;
  logic             res_vld_q, res_vld_d;
  logic             free;
  logic             pop;
  logic             load;
  logic             issue;
  logic             move;
  logic             mem_we;

  assign free        = !res_vld_q || res_ready_i;
  assign cmd_ready_o = pop;
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // Command decode and digit flush sequencing.
  always_comb begin
    st_d   = st_q;
    fidx_d = fidx_q;
    fcnt_d = fcnt_q;
    rvld_d = rvld_q;
    res_d  = res_q;
    pop    = 1'b0;
    load   = 1'b0;
    issue  = 1'b0;
    move   = 1'b0;
    mem_we = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_EMIT: begin
              if (free) begin
                pop   = 1'b1;
                load  = 1'b1;
                res_d = '{out_byte: cmd_i.data, out_valid: 1'b1, out_end: 1'b0};
              end
            end
            CMD_END: begin
              if (free) begin
                pop   = 1'b1;
                load  = 1'b1;
                res_d = '{out_byte: 8'h00, out_valid: 1'b0, out_end: 1'b1};
              end
            end
            CMD_STORE: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            CMD_FLUSH: begin
              pop    = 1'b1;
              fcnt_d = cmd_i.cnt[CNT_W-1:0];
              fidx_d = '0;
              if (cmd_i.cnt[CNT_W-1:0] != '0) begin
                st_d = BK_FLUSH;
              end
            end
            default: begin
              pop = 1'b0;
            end
          endcase
        end
      end
      BK_FLUSH: begin
        // Read one digit ahead: a digit leaves every cycle the output is free.
        move  = rvld_q && free;
        issue = (fidx_q != fcnt_q) && (!rvld_q || move);
        if (move) begin
          load  = 1'b1;
          res_d = '{out_byte: rdata_q, out_valid: 1'b1, out_end: 1'b0};
        end
        if (issue) begin
          rvld_d = 1'b1;
          fidx_d = fidx_q + CNT_W'(1);
        end else if (move) begin
          rvld_d = 1'b0;
        end
        if (move && (fidx_q == fcnt_q)) begin
          st_d = BK_IDLE;
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  assign res_vld_d = load || (res_vld_q && !res_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      fidx_q    <= '0;
      fcnt_q    <= '0;
      rvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      fidx_q    <= fidx_d;
      fcnt_q    <= fcnt_d;
      rvld_q    <= rvld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  // Digit store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digits[cmd_i.cnt[ADDR_W-1:0]] <= cmd_i.data;
    end
    if (issue) begin
      rdata_q <= digits[fidx_q[ADDR_W-1:0]];
    end
  end

endmodule

/* design/ass_dialogue_text_extractor_top.sv */
// ----------------------------------------------------------------------------
// ass_dialogue_text_extractor_top: subtitle dialogue text extractor
// Skips the leading fields of a Dialogue line, drops an optional number
// field and emits the text with override blocks and escapes resolved.
// ----------------------------------------------------------------------------
// Path: commands pass the command queue and then the result register.
// Throughput: one byte per cycle while it causes at most one command and the
// command queue has room; a byte with more (at most three) holds the input until
// its last is taken; a flush busies the back part as the four-entry queue fills.
// Reset: asynchronous and active low; the parser returns to skipping fields,
// the queue empties and the registers take their reset values.
module ass_dialogue_text_extractor_top #(
  parameter int unsigned DIGIT_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adte_pkg::in_item_t  in_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output adte_pkg::res_item_t res_o
);
  import adte_pkg::*;

  logic [3:0] fields_q;
  logic       legacy_q;
  cfg_t       cfg;
  logic       fr_valid;
  logic       fr_ready;
  cmd_t       fr_cmd;
  logic       bk_valid;
  logic       bk_ready;
  cmd_t       bk_cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= FIELDS_RESET;
      legacy_q <= LEGACY_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_FIELDS_BEFORE_TEXT) begin
        fields_q <= cfg_data_i;
      end else if (cfg_idx_i == CFG_LEGACY_NUMBER_SKIP) begin
        legacy_q <= cfg_data_i[0];
      end
    end
  end

  assign cfg = '{fields_before_text: fields_q, legacy_number_skip: legacy_q};

  adte_front #(
    .DIGIT_DEPTH(DIGIT_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(fr_ready),
    .cmd_o      (fr_cmd)
  );

  adte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_i      (fr_cmd),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_o       (bk_cmd)
  );

  adte_back #(
    .DIGIT_DEPTH(DIGIT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bk_valid),
    .cmd_ready_o(bk_ready),
    .cmd_i      (bk_cmd),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready_i),
    .res_o      (res_o)
  );

`ifndef NO_ASSERTIONS
  // A digit is only ever stored inside the digit store.
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_ready && fr_cmd.op == CMD_STORE) |->
      (fr_cmd.cnt < CMD_CNT_W'(DIGIT_DEPTH)))
    else $error("digit store address out of range");

  // A flush always covers at least one and at most a full store of digits.
  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_ready && fr_cmd.op == CMD_FLUSH) |->
      (fr_cmd.cnt != '0 && fr_cmd.cnt <= CMD_CNT_W'(DIGIT_DEPTH)))
    else $error("flush with a bad digit count");

  // The end marker is the last command of a byte, so that byte is taken.
  a_end_takes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && fr_ready && fr_cmd.op == CMD_END) |->
      (in_valid_i && in_ready_o && in_i.in_last))
    else $error("end marker transfer without the final byte");
`endif

endmodule
